[rtl/bf_pkg.sv]
package bf_pkg;

   // Image geometry
   localparam int ImageWidth  = 1024;
   localparam int ImageHeight = 768;
   localparam int RowBase     = ImageHeight - 50;

   // Fixed-point formats
   localparam int PointW  = 24;   // signed Q8.16
   localparam int CoefW   = 17;   // signed Q1.16
   localparam int TransW  = 18;   // signed Q2.16 translation, small range
   localparam int ProdW   = PointW + CoefW;
   localparam int AccW    = ProdW + 1;
   localparam int CoordW  = 16;   // signed pixel coordinate before range check
   localparam int ProbW   = 7;
   localparam int ThreshW = ProbW + 2;
   localparam int PixW    = 10;
   localparam int IndexW  = 3;

   localparam logic signed [CoefW-1:0] ScaleHundred = CoefW'(100);

   // Register indexes
   localparam logic [IndexW-1:0] RegProbFirst  = 3'd0;
   localparam logic [IndexW-1:0] RegProbSecond = 3'd1;
   localparam logic [IndexW-1:0] RegProbThird  = 3'd2;
   localparam logic [IndexW-1:0] RegStartX     = 3'd3;
   localparam logic [IndexW-1:0] RegStartY     = 3'd4;

   // Map select codes
   typedef enum logic [1:0] {
      MAP_STEM,
      MAP_LEAF,
      MAP_LEFT,
      MAP_RIGHT
   } map_type;

   // Affine coefficients a, b, c, d per map (Q1.16)
   localparam logic signed [CoefW-1:0] MapCoef [4][4] = '{
      '{17'sd0,     17'sd0,      17'sd0,     17'sd10486},
      '{17'sd55706, 17'sd2621,   -17'sd2621, 17'sd55706},
      '{17'sd13107, -17'sd17039, 17'sd15073, 17'sd14418},
      '{-17'sd9830, 17'sd18350,  17'sd17039, 17'sd15729}
   };

   // Translations e, f per map (Q2.16)
   localparam logic signed [TransW-1:0] MapTrans [4][2] = '{
      '{18'sd0, 18'sd0},
      '{18'sd0, 18'sd104858},
      '{18'sd0, 18'sd104858},
      '{18'sd0, 18'sd28836}
   };

   typedef struct packed {
      logic [ProbW-1:0]         prob_first;
      logic [ProbW-1:0]         prob_second;
      logic [ProbW-1:0]         prob_third;
      logic signed [PointW-1:0] start_x;
      logic signed [PointW-1:0] start_y;
   } cfg_type;

   typedef struct packed {
      logic [PixW-1:0] pixel_x;
      logic [PixW-1:0] pixel_y;
      logic            visible;
   } result_type;

endpackage

[rtl/bf_mul.sv]
module bf_mul
   import bf_pkg::*;
(
   input  logic                     clock,
   input  logic signed [PointW-1:0] op_a,
   input  logic signed [CoefW-1:0]  op_b,
   output logic signed [ProdW-1:0]  prod
);

   logic signed [ProdW-1:0] prod_ff;

   // Registered signed product
   always_ff @(posedge clock) begin
      prod_ff <= ProdW'(op_a) * ProdW'(op_b);
   end

   assign prod = prod_ff;

endmodule

[rtl/bf_sel.sv]
module bf_sel
   import bf_pkg::*;
(
   input  cfg_type          cfg,
   input  logic [ProbW-1:0] random_value,
   output map_type          map_sel
);

   logic [ThreshW-1:0] t1, t2, t3, r;

   // Cumulative thresholds, no saturation
   assign t1 = ThreshW'(cfg.prob_first);
   assign t2 = t1 + ThreshW'(cfg.prob_second);
   assign t3 = t2 + ThreshW'(cfg.prob_third);
   assign r  = ThreshW'(random_value);

   always_comb begin
      priority if (r < t1) map_sel = MAP_STEM;
      else if (r < t2)     map_sel = MAP_LEAF;
      else if (r < t3)     map_sel = MAP_LEFT;
      else                 map_sel = MAP_RIGHT;
   end

endmodule

[rtl/bf_core.sv]
module bf_core
   import bf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             start,
   input  logic             first,
   input  map_type          map_sel,
   input  logic             out_free,
   output logic             idle,
   output logic             done,
   output result_type       result
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_AX,
      S_BY,
      S_CX,
      S_DY,
      S_SX,
      S_SY,
      S_FIN
   } state_type;

   localparam logic signed [AccW-1:0]   RoundHalf = AccW'(32768);
   localparam logic signed [ProdW-1:0]  TruncBias = ProdW'(65535);
   localparam logic signed [PointW:0]   PointMax  = {2'b00, {(PointW-1){1'b1}}};
   localparam logic signed [PointW:0]   PointMin  = {2'b11, {(PointW-1){1'b0}}};
   localparam logic signed [CoordW-1:0] HalfWidth = CoordW'(ImageWidth / 2);
   localparam logic signed [CoordW-1:0] RowOrigin = CoordW'(RowBase);
   localparam logic signed [CoordW-1:0] WidthS    = CoordW'(ImageWidth);
   localparam logic signed [CoordW-1:0] HeightS   = CoordW'(ImageHeight);

   state_type               state_ff, state_in;
   map_type                 map_ff, map_in;
   logic signed [PointW-1:0] point_x_ff, point_x_in;
   logic signed [PointW-1:0] point_y_ff, point_y_in;
   logic signed [ProdW-1:0]  acc_ff, acc_in;
   logic signed [CoordW-1:0] col_ff, col_in;

   logic signed [PointW-1:0] op_a;
   logic signed [CoefW-1:0]  op_b;
   logic signed [ProdW-1:0]  prod;

   logic signed [AccW-1:0]   sum;
   logic signed [AccW-17:0]  rounded;
   logic signed [TransW-1:0] trans;
   logic signed [AccW-16:0]  moved;
   logic signed [PointW-1:0] sat_point;
   logic signed [ProdW-1:0]  biased;
   logic signed [CoordW-1:0] scaled;
   logic signed [CoordW-1:0] row;
   logic                     vis;

   bf_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         S_AX:    begin op_a = point_x_ff; op_b = MapCoef[map_ff][0]; end
         S_BY:    begin op_a = point_y_ff; op_b = MapCoef[map_ff][1]; end
         S_CX:    begin op_a = point_x_ff; op_b = MapCoef[map_ff][2]; end
         S_DY:    begin op_a = point_y_ff; op_b = MapCoef[map_ff][3]; end
         S_SX:    begin op_a = point_x_ff; op_b = ScaleHundred; end
         default: begin op_a = point_y_ff; op_b = ScaleHundred; end
      endcase
   end

   // New coordinate: round the product sum, add translation, saturate
   assign trans   = (state_ff == S_CX) ? MapTrans[map_ff][0] : MapTrans[map_ff][1];
   assign sum     = AccW'(acc_ff) + AccW'(prod) + RoundHalf;
   assign rounded = sum[AccW-1:16];
   assign moved   = (AccW-15)'(rounded) + (AccW-15)'(trans);

   always_comb begin
      priority if (moved > (AccW-15)'(PointMax))      sat_point = PointMax[PointW-1:0];
      else if (moved < (AccW-15)'(PointMin))          sat_point = PointMin[PointW-1:0];
      else                                             sat_point = moved[PointW-1:0];
   end

   // Scale by 100, truncate toward zero
   assign biased = prod + (prod[ProdW-1] ? TruncBias : '0);
   assign scaled = biased[16 +: CoordW];
   assign row    = RowOrigin - scaled;
   assign vis    = !col_ff[CoordW-1] && (col_ff < WidthS) &&
                   !row[CoordW-1] && (row < HeightS);

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_FIN) && out_free;

   always_comb begin
      result.visible = vis;
      result.pixel_x = vis ? col_ff[PixW-1:0] : '0;
      result.pixel_y = vis ? row[PixW-1:0] : '0;
   end

   // Sequencer next state
   always_comb begin
      state_in   = state_ff;
      map_in     = map_ff;
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      acc_in     = acc_ff;
      col_in     = col_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               map_in   = map_sel;
               state_in = S_AX;
               if (first) begin
                  point_x_in = cfg.start_x;
                  point_y_in = cfg.start_y;
               end
            end
            acc_in = '0;
         end
         S_AX: state_in = S_BY;
         S_BY: begin
            acc_in   = prod;
            state_in = S_CX;
         end
         S_CX: begin
            point_x_in = sat_point;
            acc_in     = '0;
            state_in   = S_DY;
         end
         S_DY: begin
            acc_in   = prod;
            state_in = S_SX;
         end
         S_SX: begin
            point_y_in = sat_point;
            acc_in     = '0;
            state_in   = S_SY;
         end
         S_SY: begin
            col_in   = scaled + HalfWidth;
            state_in = S_FIN;
         end
         S_FIN: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         point_x_ff <= '0;
         point_y_ff <= '0;
      end else begin
         state_ff   <= state_in;
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
      end
      map_ff <= map_in;
      acc_ff <= acc_in;
      col_ff <= col_in;
   end

endmodule

[rtl/barnsley_fern_ifs_point_generator.sv]
// Barnsley fern chaos-game point generator.
// Input stream req_*: one item per step. tdata carries random_value, kept
// in 0..99 by the user (unchecked); tuser carries first_step, which reloads
// the point from start_x/start_y before the step. Each item gives exactly
// one result on rsp_*: tdata holds pixel_x and pixel_y, tuser holds visible
// (pixels are 0 when not visible). Config port csr_*: index 0..4 selects
// prob_first, prob_second, prob_third, start_x, start_y; always ready, write
// only while the block is idle. One multiplier is shared by the four map
// products and the two scalings by 100, which the core runs as the states
// S_AX, S_BY, S_CX, S_DY, S_SX, S_SY and S_FIN, from which the result goes
// into the output register; req_tready rises in the same cycle as
// rsp_tvalid, so an item is taken only once the core is done with the last.
// A result waits in the output register while rsp_tready is low; a new item
// can still be accepted then, and the core holds its finished result until
// the register frees.
// Synchronous reset clears the point to 0, restores the published 1/85/7
// split and start point 0, and empties the output register.
module barnsley_fern_ifs_point_generator
   import bf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [6:0] random_value, [7] zero
   input  logic [0:0]        req_tuser,   // [0] first_step
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
   output logic [0:0]        rsp_tuser,   // [0] visible
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IndexW-1:0] csr_index,
   input  logic [23:0]       csr_data
);

   cfg_type    cfg_ff, cfg_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   map_type    map_sel;
   logic       idle, done, out_free, start;
   result_type result;

   assign csr_ready = 1'b1;
   assign start     = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   bf_sel u_sel (
      .cfg          (cfg_ff),
      .random_value (req_tdata[ProbW-1:0]),
      .map_sel      (map_sel)
   );

   bf_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .start    (start),
      .first    (req_tuser[0]),
      .map_sel  (map_sel),
      .out_free (out_free),
      .idle     (idle),
      .done     (done),
      .result   (result)
   );

   assign req_tready = idle;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegProbFirst:  cfg_in.prob_first  = csr_data[ProbW-1:0];
            RegProbSecond: cfg_in.prob_second = csr_data[ProbW-1:0];
            RegProbThird:  cfg_in.prob_third  = csr_data[ProbW-1:0];
            RegStartX:     cfg_in.start_x     = csr_data[PointW-1:0];
            RegStartY:     cfg_in.start_y     = csr_data[PointW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prob_first  <= 7'd1;
         cfg_ff.prob_second <= 7'd85;
         cfg_ff.prob_third  <= 7'd7;
         cfg_ff.start_x     <= '0;
         cfg_ff.start_y     <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {4'b0, rsp_ff.pixel_y, rsp_ff.pixel_x};
   assign rsp_tuser[0] = rsp_ff.visible;

`ifndef SYNTH
   // An off-image point carries zero pixel fields
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 24'd0)
      else $error("hidden point with nonzero pixel");

   // The block is busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule
